// File: src/s2uv_pkg.sv
// shared types, widths and the arctangent table for the spherical to unit vector block
// no dependencies

package s2uv_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int OUT_BITS     = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int FRAC_BITS    = 30;
  localparam int CW           = 32;
  // input register, cordic steps, quadrant fold, multiply, round
  localparam int STAGES       = CORDIC_STEPS + 4;

  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  typedef logic [ANGLE_BITS-1:0]      angle_t;
  typedef logic signed [OUT_BITS-1:0] sample_t;
  typedef logic signed [CW-1:0]       cval_t;
  typedef logic [1:0]                 quad_t;

  typedef struct packed {
    angle_t azimuth;
    angle_t polar;
  } in_item_t;

  typedef struct packed {
    sample_t x_out;
    sample_t y_out;
    sample_t z_out;
  } out_item_t;

  // rotation angle of each step, 2^32 units per turn
  function automatic logic [CW-1:0] atan_turn32(input logic [4:0] idx);
    logic [CW-1:0] a;
    unique case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: src/spherical_to_unit_vector.sv
// Converts an azimuth and polar binary angle into the Cartesian unit vector
// (sin(theta)cos(phi), sin(theta)sin(phi), cos(theta)) in signed Q1.15, with +1
// saturating to the largest positive code. One request is taken every cycle while in_stall is low. The pipe
// is 34 registers deep: the input register, one cordic rotation step per stage (30
// stages, both angles side by side), the quadrant fold, the multiply and the rounding
// register; out_valid is the valid bit of the rounding register. Output stall only
// holds the input side once every stage holds a request; bubbles in the pipe are
// squeezed out.
// Depends on s2uv_pkg, s2uv_sincos and s2uv_out_stage.

module spherical_to_unit_vector (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  s2uv_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output s2uv_pkg::out_item_t  out_data
);

  localparam int NST = s2uv_pkg::STAGES;
  localparam int NC  = s2uv_pkg::CORDIC_STEPS;

  logic [NST-1:0]      v_r, v_nxt, en, shift_in;
  s2uv_pkg::in_item_t  in_r;
  s2uv_pkg::cval_t     cp, sp, ct, st;

  // a stage may load unless it and everything after it are full and the output is held
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = ~((&v_r[NST-1:k]) & out_stall);
  end

  assign shift_in = {v_r[NST-2:0], in_valid};
  assign v_nxt    = (en & shift_in) | (~en & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      in_r <= in_data;
    end
  end

  s2uv_sincos u_phi (
    .clk     (clk),
    .en_i    (en[NC+1:1]),
    .angle_i (in_r.azimuth),
    .cos_o   (cp),
    .sin_o   (sp)
  );

  s2uv_sincos u_theta (
    .clk     (clk),
    .en_i    (en[NC+1:1]),
    .angle_i (in_r.polar),
    .cos_o   (ct),
    .sin_o   (st)
  );

  s2uv_out_stage u_out (
    .clk    (clk),
    .en_i   (en[NC+3:NC+2]),
    .cp_i   (cp),
    .sp_i   (sp),
    .ct_i   (ct),
    .st_i   (st),
    .item_o (out_data)
  );

  assign in_stall  = ~en[0];
  assign out_valid = v_r[NST-1];

endmodule

// File: src/s2uv_cordic_step.sv
// one registered rotation step of the sine/cosine cordic
// depends on s2uv_pkg

module s2uv_cordic_step #(
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic               en,
  input  s2uv_pkg::cval_t    x_i,
  input  s2uv_pkg::cval_t    y_i,
  input  s2uv_pkg::cval_t    z_i,
  input  s2uv_pkg::quad_t    quad_i,
  output s2uv_pkg::cval_t    x_o,
  output s2uv_pkg::cval_t    y_o,
  output s2uv_pkg::cval_t    z_o,
  output s2uv_pkg::quad_t    quad_o
);

  s2uv_pkg::cval_t x_r, y_r, z_r;
  s2uv_pkg::cval_t x_nxt, y_nxt, z_nxt;
  s2uv_pkg::quad_t quad_r;
  s2uv_pkg::cval_t dx, dy, ang;

  always_comb begin
    dx  = x_i;
    dy  = y_i;
    dx  = y_i >>> STEP;
    dy  = x_i >>> STEP;
    ang = $signed(s2uv_pkg::atan_turn32(5'(STEP)));
    // rotate forward while the remaining angle is not negative
    if (!z_i[s2uv_pkg::CW-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ang;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      quad_r <= quad_i;
    end
  end

  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign quad_o = quad_r;

endmodule

// File: src/s2uv_sincos.sv
// pipelined cosine and sine of one binary angle, one cordic step per stage,
// then a quadrant fold; depends on s2uv_pkg and s2uv_cordic_step

module s2uv_sincos (
  input  logic                                clk,
  input  logic [s2uv_pkg::CORDIC_STEPS:0]     en_i,
  input  s2uv_pkg::angle_t                    angle_i,
  output s2uv_pkg::cval_t                     cos_o,
  output s2uv_pkg::cval_t                     sin_o
);

  localparam int N = s2uv_pkg::CORDIC_STEPS;

  logic [31:0]     a32;
  s2uv_pkg::cval_t x_w [0:N];
  s2uv_pkg::cval_t y_w [0:N];
  s2uv_pkg::cval_t z_w [0:N];
  s2uv_pkg::quad_t quad_w [0:N];
  s2uv_pkg::cval_t cos_r, sin_r, cos_nxt, sin_nxt;

  // widen to a 32-bit binary angle: top two bits quadrant, rest residual
  assign a32       = {angle_i, {(32 - s2uv_pkg::ANGLE_BITS){1'b0}}};
  assign quad_w[0] = a32[31:30];
  assign z_w[0]    = $signed({2'b00, a32[29:0]});
  assign x_w[0]    = s2uv_pkg::CORDIC_GAIN_Q30;
  assign y_w[0]    = '0;

  for (genvar i = 0; i < N; i++) begin : g_step
    s2uv_cordic_step #(
      .STEP(i)
    ) u_step (
      .clk    (clk),
      .en     (en_i[i]),
      .x_i    (x_w[i]),
      .y_i    (y_w[i]),
      .z_i    (z_w[i]),
      .quad_i (quad_w[i]),
      .x_o    (x_w[i+1]),
      .y_o    (y_w[i+1]),
      .z_o    (z_w[i+1]),
      .quad_o (quad_w[i+1])
    );
  end

  always_comb begin
    unique case (quad_w[N])
      2'd0: begin
        cos_nxt = x_w[N];
        sin_nxt = y_w[N];
      end
      2'd1: begin
        cos_nxt = -y_w[N];
        sin_nxt = x_w[N];
      end
      2'd2: begin
        cos_nxt = -x_w[N];
        sin_nxt = -y_w[N];
      end
      2'd3: begin
        cos_nxt = y_w[N];
        sin_nxt = -x_w[N];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_i[N]) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

// File: src/s2uv_out_stage.sv
// products of the angle terms, then rounding and saturation to the output format
// depends on s2uv_pkg

module s2uv_out_stage (
  input  logic                 clk,
  input  logic [1:0]           en_i,
  input  s2uv_pkg::cval_t      cp_i,
  input  s2uv_pkg::cval_t      sp_i,
  input  s2uv_pkg::cval_t      ct_i,
  input  s2uv_pkg::cval_t      st_i,
  output s2uv_pkg::out_item_t  item_o
);

  localparam int CW  = s2uv_pkg::CW;
  localparam int PW  = 2 * CW;
  localparam int OB  = s2uv_pkg::OUT_BITS;
  localparam int SHP = 2 * s2uv_pkg::FRAC_BITS - (OB - 1);
  localparam int SHZ = s2uv_pkg::FRAC_BITS - (OB - 1);

  localparam logic signed [PW-1:0] HALF_P = PW'(longint'(1) << (SHP - 1));
  localparam logic signed [PW-1:0] HI_P   = PW'((longint'(1) << (OB - 1)) - 1);
  localparam logic signed [PW-1:0] LO_P   = -HI_P - PW'(1);
  localparam logic signed [CW-1:0] HALF_Z = CW'(longint'(1) << (SHZ - 1));
  localparam logic signed [CW-1:0] HI_Z   = CW'((longint'(1) << (OB - 1)) - 1);
  localparam logic signed [CW-1:0] LO_Z   = -HI_Z - CW'(1);

  logic signed [PW-1:0] px_r, py_r, px_nxt, py_nxt;
  logic signed [PW-1:0] px_rnd, py_rnd;
  s2uv_pkg::cval_t      zc_r, z_rnd;
  s2uv_pkg::out_item_t  item_r, item_nxt;

  function automatic s2uv_pkg::sample_t sat_p(input logic signed [PW-1:0] v);
    s2uv_pkg::sample_t s;
    priority if (v > HI_P) s = HI_P[OB-1:0];
    else if (v < LO_P)     s = LO_P[OB-1:0];
    else                   s = v[OB-1:0];
    return s;
  endfunction

  function automatic s2uv_pkg::sample_t sat_z(input s2uv_pkg::cval_t v);
    s2uv_pkg::sample_t s;
    priority if (v > HI_Z) s = HI_Z[OB-1:0];
    else if (v < LO_Z)     s = LO_Z[OB-1:0];
    else                   s = v[OB-1:0];
    return s;
  endfunction

  assign px_nxt = PW'(st_i) * PW'(cp_i);
  assign py_nxt = PW'(st_i) * PW'(sp_i);

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      zc_r <= ct_i;
    end
  end

  // add half an output lsb, then floor shift
  assign px_rnd = (px_r + HALF_P) >>> SHP;
  assign py_rnd = (py_r + HALF_P) >>> SHP;
  assign z_rnd  = (zc_r + HALF_Z) >>> SHZ;

  always_comb begin
    item_nxt.x_out = sat_p(px_rnd);
    item_nxt.y_out = sat_p(py_rnd);
    item_nxt.z_out = sat_z(z_rnd);
  end

  always_ff @(posedge clk) begin
    if (en_i[1]) begin
      item_r <= item_nxt;
    end
  end

  assign item_o = item_r;

endmodule

// File: src/s2uv_checker.sv
// port-level checks for spherical_to_unit_vector, bound to the top level
// depends on s2uv_pkg

module s2uv_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input s2uv_pkg::in_item_t   in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input s2uv_pkg::out_item_t  out_data
);

  // pipe comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // the input side only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // a stalled request holds still
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
    else $error("stalled request changed or dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("held result changed or dropped");

  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result withdrawn while stalled");

endmodule

bind spherical_to_unit_vector s2uv_checker u_s2uv_checker (.*);

// File: bench/tb.sv
// testbench for spherical_to_unit_vector: directed table then random requests,
// with idling on both sides
// depends on s2uv_pkg and the spherical_to_unit_vector rtl
`timescale 1ns / 1ps

module tb;

  localparam longint ROT_GAIN = 64'sd652032874;
  localparam int N_DIR = 18;
  localparam int N_RAND = 500;

  localparam s2uv_pkg::sample_t POS1 = 16'sh7FFF;
  localparam s2uv_pkg::sample_t NEG1 = 16'sh8000;
  localparam s2uv_pkg::sample_t ZERO = 16'sh0000;

  typedef struct packed {
    logic              typed;
    s2uv_pkg::angle_t  az;
    s2uv_pkg::angle_t  pol;
    s2uv_pkg::sample_t x;
    s2uv_pkg::sample_t y;
    s2uv_pkg::sample_t z;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  s2uv_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  s2uv_pkg::out_item_t out_data;

  s2uv_pkg::out_item_t vector_q[$];
  int        fail_count = 0;
  bit        no_idle = 1'b0;
  int        stall_left = 0;
  int        free_left = 0;

  // rotation angle per cordic step, 2^32 units per turn
  longint rot_step [30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
  };

  // typed rows are the poles and axis points, where the answer is plain
  dir_row_t dir_rows [N_DIR] = '{
    {1'b1, 16'h0000, 16'h0000, ZERO, ZERO, POS1},
    {1'b1, 16'h0000, 16'h4000, POS1, ZERO, ZERO},
    {1'b1, 16'h4000, 16'h4000, ZERO, POS1, ZERO},
    {1'b1, 16'h8000, 16'h4000, NEG1, ZERO, ZERO},
    {1'b1, 16'hC000, 16'h4000, ZERO, NEG1, ZERO},
    {1'b1, 16'h0000, 16'h8000, ZERO, ZERO, NEG1},
    {1'b1, 16'h0000, 16'hC000, NEG1, ZERO, ZERO},
    {1'b0, 16'hFFFF, 16'hFFFF, ZERO, ZERO, ZERO},
    {1'b0, 16'h0001, 16'h0001, ZERO, ZERO, ZERO},
    {1'b0, 16'h7FFF, 16'h8001, ZERO, ZERO, ZERO},
    {1'b0, 16'h2000, 16'h2000, ZERO, ZERO, ZERO},
    {1'b0, 16'hFFFF, 16'h0000, ZERO, ZERO, ZERO},
    {1'b0, 16'h0000, 16'hFFFF, ZERO, ZERO, ZERO},
    {1'b0, 16'hAAAA, 16'h5555, ZERO, ZERO, ZERO},
    {1'b0, 16'h5555, 16'hAAAA, ZERO, ZERO, ZERO},
    {1'b0, 16'hE000, 16'h6000, ZERO, ZERO, ZERO},
    {1'b0, 16'h1234, 16'h3FFF, ZERO, ZERO, ZERO},
    {1'b0, 16'hC001, 16'hBFFF, ZERO, ZERO, ZERO}
  };

  spherical_to_unit_vector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // cosine and sine of a binary angle in Q30
  function automatic void cos_sin_q30(input s2uv_pkg::angle_t ang,
                                      output longint c, output longint s);
    logic [31:0] a32;
    longint      x, y, z, dx, dy;
    a32 = 32'(ang) << (32 - s2uv_pkg::ANGLE_BITS);
    z = {34'd0, a32[29:0]};
    x = ROT_GAIN;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - rot_step[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + rot_step[i];
      end
    end
    case (a32[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  // round to the output fraction, then clamp so +1 lands on the top code
  function automatic s2uv_pkg::sample_t round_sat(input longint v, input int frac);
    int     sh;
    longint r, top;
    sh = frac - (s2uv_pkg::OUT_BITS - 1);
    top = (longint'(1) << (s2uv_pkg::OUT_BITS - 1)) - 1;
    r = (v + (longint'(1) << (sh - 1))) >>> sh;
    if (r > top) r = top;
    if (r < -top - 1) r = -top - 1;
    return r[s2uv_pkg::OUT_BITS-1:0];
  endfunction

  function automatic s2uv_pkg::out_item_t unit_vector(input s2uv_pkg::in_item_t req);
    longint              cp, sp, ct, st;
    s2uv_pkg::out_item_t v;
    cos_sin_q30(req.azimuth, cp, sp);
    cos_sin_q30(req.polar, ct, st);
    v.x_out = round_sat(st * cp, 60);
    v.y_out = round_sat(st * sp, 60);
    v.z_out = round_sat(ct, 30);
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic s2uv_pkg::angle_t pick_angle();
    int r;
    r = $urandom_range(99);
    // mostly anywhere, some hugging a quadrant edge
    if (r < 70) return s2uv_pkg::angle_t'($urandom);
    if (r < 90) begin
      return s2uv_pkg::angle_t'(($urandom_range(3) << 14) + $urandom_range(6) - 3);
    end
    return $urandom_range(1) ? '1 : '0;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // one request: optional gap, then hold until taken
  task automatic send_req(input s2uv_pkg::in_item_t req, input logic typed,
                          input s2uv_pkg::out_item_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    vector_q.push_back(typed ? want : unit_vector(req));
  endtask

  // output stall: runs of free cycles then short or long stalls
  always @(posedge clk) begin
    if (no_idle) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (free_left > 0) begin
      free_left <= free_left - 1;
      out_stall <= 1'b0;
    end else begin
      free_left  <= $urandom_range(20);
      stall_left <= ($urandom_range(9) == 0) ? $urandom_range(60, 15) : $urandom_range(3);
      out_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    s2uv_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (vector_q.size() == 0) begin
        note_failure($sformatf("tb: unexpected result x=%0d y=%0d z=%0d",
                               out_data.x_out, out_data.y_out, out_data.z_out));
      end else begin
        want = vector_q.pop_front();
        if (out_data.x_out !== want.x_out || out_data.y_out !== want.y_out ||
            out_data.z_out !== want.z_out) begin
          note_failure($sformatf("tb: mismatch exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                 want.x_out, want.y_out, want.z_out,
                                 out_data.x_out, out_data.y_out, out_data.z_out));
        end
      end
    end
  end

  initial begin
    s2uv_pkg::in_item_t  req;
    s2uv_pkg::out_item_t want;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      req.azimuth = dir_rows[i].az;
      req.polar   = dir_rows[i].pol;
      want.x_out  = dir_rows[i].x;
      want.y_out  = dir_rows[i].y;
      want.z_out  = dir_rows[i].z;
      send_req(req, dir_rows[i].typed, want);
    end

    for (int n = 0; n < N_RAND; n++) begin
      // every fifty requests, sometimes a stretch with no idling at all
      if (n % 50 == 0) no_idle = ($urandom_range(3) == 0);
      req.azimuth = pick_angle();
      req.polar   = pick_angle();
      send_req(req, 1'b0, '0);
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (vector_q.size() > 0) @(posedge clk);
    repeat (s2uv_pkg::STAGES + 8) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
